// File: sv/cfe_pkg.sv
`timescale 1ns / 1ps
package cfe_pkg;

    localparam logic [15:0] DJB_SEED = 16'd5381;
    // first djb step on the seed is constant: seed * 33 mod 2^16
    localparam logic [15:0] DJB_H0 = 16'((32'(DJB_SEED) * 32'd33) & 32'hFFFF);

    localparam logic [7:0] RELOC_RESET = 8'd8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH_FP,
        ST_CHECK1,
        ST_CHECK2,
        ST_RELOC_HASH,
        ST_RELOC_MOVE
    } state_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] lost;
    } result_t;

endpackage

// File: sv/cfe_hash.sv
`timescale 1ns / 1ps
module cfe_hash
    import cfe_pkg::*;
(
    input  logic [15:0] value,
    output logic [15:0] hash
);

    logic [15:0] h0;

    // h = h*33 + byte, low byte first; *33 is shift plus add
    always_comb
    begin
        h0   = DJB_H0 + {8'd0, value[7:0]};
        hash = {h0[10:0], 5'd0} + h0 + {8'd0, value[15:8]};
    end

endmodule

// File: sv/cfe_mem.sv
`timescale 1ns / 1ps
module cfe_mem #(
    parameter int BUCKET_COUNT = 128
) (
    input  logic                            clk,
    input  logic                            rd_en,
    input  logic [$clog2(BUCKET_COUNT)-1:0] rd_addr,
    output logic [15:0]                     rd_data,
    input  logic                            wr_en,
    input  logic [$clog2(BUCKET_COUNT)-1:0] wr_addr,
    input  logic [15:0]                     wr_data
);

    logic [15:0] mem [BUCKET_COUNT];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/cfe_ctrl.sv
`timescale 1ns / 1ps
module cfe_ctrl
    import cfe_pkg::*;
#(
    parameter int BUCKET_COUNT = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            opcode,
    input  logic [15:0]                     key,
    input  logic                            evict_first,
    input  logic [7:0]                      max_reloc,
    output logic                            busy,
    output logic [15:0]                     hash_in,
    input  logic [15:0]                     hash_out,
    output logic                            mem_rd_en,
    output logic [$clog2(BUCKET_COUNT)-1:0] mem_rd_addr,
    input  logic [15:0]                     mem_rd_data,
    output logic                            mem_wr_en,
    output logic [$clog2(BUCKET_COUNT)-1:0] mem_wr_addr,
    output logic [15:0]                     mem_wr_data,
    output logic                            done,
    output result_t                         res
);

    localparam int IDX_W = $clog2(BUCKET_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKET_COUNT - 1);

    state_t state_reg, state_next;

    logic             op_reg, op_next;
    logic             evict_reg, evict_next;
    logic [15:0]      fp_reg, fp_next;
    logic [IDX_W-1:0] i1_reg, i1_next;
    logic [IDX_W-1:0] i2_reg, i2_next;
    logic [15:0]      e1_reg, e1_next;
    logic [IDX_W-1:0] vidx_reg, vidx_next;
    logic [15:0]      victim_reg, victim_next;
    logic [7:0]       count_reg, count_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic             done_reg, done_next;
    result_t          res_reg, res_next;

    logic             accept;
    logic [IDX_W-1:0] alt_idx;
    logic [8:0]       count_inc;
    logic             give_up;
    logic             fin;
    logic             fin_ok;
    logic [15:0]      fin_lost;

    assign accept    = (state_reg == ST_IDLE) && start;
    assign alt_idx   = vidx_reg ^ hash_out[IDX_W-1:0];
    assign count_inc = {1'b0, count_reg} + 9'd1;
    assign give_up   = count_inc >= {1'b0, max_reloc};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_HASH_FP;
                end
            end
            ST_HASH_FP:
            begin
                state_next = ST_CHECK1;
            end
            ST_CHECK1:
            begin
                if (op_reg == OP_INSERT && mem_rd_data == 16'd0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_CHECK2;
                end
            end
            ST_CHECK2:
            begin
                if (op_reg == OP_LOOKUP || mem_rd_data == 16'd0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RELOC_HASH;
                end
            end
            ST_RELOC_HASH:
            begin
                state_next = ST_RELOC_MOVE;
            end
            ST_RELOC_MOVE:
            begin
                if (mem_rd_data == 16'd0 || give_up)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RELOC_HASH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs: hash select and memory port
    always_comb
    begin
        hash_in     = fp_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = i2_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = i1_reg;
        mem_wr_data = fp_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wr_data = 16'd0;
            end
            ST_IDLE:
            begin
                hash_in = key;
            end
            ST_HASH_FP:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = fp_reg[IDX_W-1:0];
            end
            ST_CHECK1:
            begin
                mem_rd_en = 1'b1;
                if (op_reg == OP_INSERT && mem_rd_data == 16'd0)
                begin
                    mem_wr_en = 1'b1;
                end
            end
            ST_CHECK2:
            begin
                if (op_reg == OP_INSERT)
                begin
                    mem_wr_en = 1'b1;
                    if (mem_rd_data == 16'd0 || !evict_reg)
                    begin
                        mem_wr_addr = i2_reg;
                    end
                end
            end
            ST_RELOC_HASH:
            begin
                hash_in     = victim_reg;
                mem_rd_en   = 1'b1;
                mem_rd_addr = alt_idx;
            end
            ST_RELOC_MOVE:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = vidx_reg;
                mem_wr_data = victim_reg;
            end
            default:
            begin
                hash_in = fp_reg;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        op_next     = op_reg;
        evict_next  = evict_reg;
        fp_next     = fp_reg;
        i1_next     = i1_reg;
        i2_next     = i2_reg;
        e1_next     = e1_reg;
        vidx_next   = vidx_reg;
        victim_next = victim_reg;
        count_next  = count_reg;
        clr_next    = clr_reg;
        fin         = 1'b0;
        fin_ok      = 1'b1;
        fin_lost    = 16'd0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + IDX_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = opcode;
                    evict_next = evict_first;
                    fp_next    = hash_out;
                end
            end
            ST_HASH_FP:
            begin
                i1_next = fp_reg[IDX_W-1:0];
                i2_next = fp_reg[IDX_W-1:0] ^ hash_out[IDX_W-1:0];
            end
            ST_CHECK1:
            begin
                e1_next = mem_rd_data;
                if (op_reg == OP_INSERT && mem_rd_data == 16'd0)
                begin
                    fin = 1'b1;
                end
            end
            ST_CHECK2:
            begin
                if (op_reg == OP_LOOKUP)
                begin
                    fin    = 1'b1;
                    fin_ok = (e1_reg == fp_reg) || (mem_rd_data == fp_reg);
                end
                else if (mem_rd_data == 16'd0)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    vidx_next   = evict_reg ? i1_reg : i2_reg;
                    victim_next = evict_reg ? e1_reg : mem_rd_data;
                    count_next  = 8'd0;
                end
            end
            ST_RELOC_HASH:
            begin
                vidx_next = alt_idx;
            end
            ST_RELOC_MOVE:
            begin
                victim_next = mem_rd_data;
                if (mem_rd_data == 16'd0)
                begin
                    fin = 1'b1;
                end
                else if (give_up)
                begin
                    fin      = 1'b1;
                    fin_ok   = 1'b0;
                    fin_lost = mem_rd_data;
                end
                else
                begin
                    count_next = count_inc[7:0];
                end
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
        done_next = fin;
        res_next  = fin ? result_t'{ok: fin_ok, lost: fin_lost} : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        evict_reg  <= evict_next;
        fp_reg     <= fp_next;
        i1_reg     <= i1_next;
        i2_reg     <= i2_next;
        e1_reg     <= e1_next;
        vidx_reg   <= vidx_next;
        victim_reg <= victim_next;
        count_reg  <= count_next;
        res_reg    <= res_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

endmodule

// File: sv/cuckoo_filter_engine_top.sv
`timescale 1ns / 1ps
// An insert into an empty first bucket passes ST_HASH_FP and ST_CHECK1 before done;
// a lookup or a second-bucket insert also passes ST_CHECK2, then any relocations follow.
// Each relocation hashes and reads in ST_RELOC_HASH, then writes in ST_RELOC_MOVE.
// A new word is accepted only in idle; busy stays high until done, results cannot stall.
// Reset: after rst_n releases, busy stays high while the table clears.
module cuckoo_filter_engine_top
    import cfe_pkg::*;
#(
    parameter int BUCKET_COUNT = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [15:0] key,
    input  logic        evict_first,
    output logic        done,
    output logic        ok,
    output logic [15:0] lost_fingerprint,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int IDX_W = $clog2(BUCKET_COUNT);

    logic [7:0]       max_reloc_reg;
    logic [15:0]      hash_in;
    logic [15:0]      hash_out;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    logic [15:0]      mem_rd_data;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    logic [15:0]      mem_wr_data;
    result_t          res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reloc_reg <= RELOC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_reloc_reg <= cfg_data;
        end
    end

    cfe_hash u_hash (
        .value (hash_in),
        .hash  (hash_out)
    );

    cfe_mem #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    cfe_ctrl #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (opcode),
        .key         (key),
        .evict_first (evict_first),
        .max_reloc   (max_reloc_reg),
        .busy        (busy),
        .hash_in     (hash_in),
        .hash_out    (hash_out),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .done        (done),
        .res         (res)
    );

    assign ok               = res.ok;
    assign lost_fingerprint = res.lost;

endmodule

// File: sv/cfe_checker.sv
`timescale 1ns / 1ps
module cfe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        ok,
    input logic [15:0] lost_fingerprint
);

    // an accepted word keeps the engine busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after accept");

    // no result can come out the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result too soon after accept");

    // the engine is free again whenever a result shows
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // a dropped fingerprint only goes with a failed insert
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && ok) |-> (lost_fingerprint == 16'd0))
        else $error("lost fingerprint on success");

endmodule

bind cuckoo_filter_engine_top cfe_checker u_cfe_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .ok               (ok),
    .lost_fingerprint (lost_fingerprint)
);
